[sv/imuoc_pkg.sv]
// Shared types and constants for the inertial sensor offset calibrator.
`timescale 1ns / 1ps

package imuoc_pkg;

   localparam int AXES     = 6;
   localparam int SMP_W    = 16;
   localparam int SUM_W    = 32;
   localparam int CNT_W    = 16;
   localparam int GRAV_W   = 15;
   localparam int ID_W     = 8;
   localparam int AXIS_AZ  = 2;

   localparam int SAMPLES_DEFAULT = 256;

   // Averaging sequence: a load step, one multiply step per part of the
   // sum, then a finish step.
   localparam int MUL_STEPS = 2;
   localparam int DIV_LAST  = MUL_STEPS + 1;
   localparam int DCNT_W    = $clog2(DIV_LAST + 1);

   localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16384;
   localparam logic [ID_W-1:0]   ID_EXPECTED   = 8'h68;

   typedef enum logic [1:0] {
      PH_CHECK,
      PH_WAKE,
      PH_CALIB,
      PH_NORMAL
   } phase_type;

   typedef enum logic [1:0] {
      OP_ID_READ,
      OP_WAKE_DONE,
      OP_FRAME,
      OP_BUS_ERROR
   } op_type;

   typedef struct packed {
      logic accumulate;
      logic first;
      logic load;
      logic step;
      logic finish;
   } lane_ctl_type;

   typedef struct packed {
      phase_type                    phase;
      logic                         sample_valid;
      logic                         calibration_done;
      logic [AXES-1:0][SMP_W-1:0]   samples;
   } result_type;

endpackage

[sv/imuoc_lane.sv]
// One axis lane: running sum, averaging by reciprocal multiplication, offset and correction.
`timescale 1ns / 1ps

module imuoc_lane import imuoc_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEFAULT
) (
   input  logic                     clock,
   input  lane_ctl_type             ctl,
   input  logic signed [SMP_W-1:0]  sample_in,
   input  logic [GRAV_W-1:0]        adjust,
   output logic [SMP_W-1:0]         corrected_out
);

   // A magnitude below 2**SUM_W divided by SAMPLES equals
   // (magnitude * RECIP) >> (SUM_W + SHIFT) with this choice of RECIP.
   localparam int PART_W = SUM_W / MUL_STEPS;
   localparam int RCP_W  = SUM_W + 1;
   localparam int PROD_W = PART_W + RCP_W;
   localparam int ACC_W  = 2 * SUM_W;
   localparam int SHIFT  = $clog2(SAMPLES);
   localparam logic [ACC_W-1:0] RECIP_FULL =
      ((ACC_W'(1) << (SUM_W + SHIFT)) / ACC_W'(SAMPLES)) + ACC_W'(1);
   localparam logic [RCP_W-1:0] RECIP = RECIP_FULL[RCP_W-1:0];

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] mag_ff, mag_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [SMP_W-1:0] offset_ff, offset_in;

   logic [SUM_W-1:0]  base;
   logic [PROD_W-1:0] partial;
   logic [SMP_W-1:0]  quot_mag;
   logic [SMP_W-1:0]  quot;

   always_comb begin
      base     = ctl.first ? '0 : sum_ff;
      partial  = PROD_W'(mag_ff[SUM_W-1:PART_W]) * PROD_W'(RECIP);
      // The offset wraps at 16 bits, so only the low quotient bits matter.
      quot_mag = acc_ff[SUM_W + SHIFT +: SMP_W];
      quot     = neg_ff ? (SMP_W'(0) - quot_mag) : quot_mag;

      sum_in    = sum_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      offset_in = offset_ff;

      if (ctl.accumulate) begin
         sum_in = base + {{(SUM_W-SMP_W){sample_in[SMP_W-1]}}, sample_in};
      end
      // Divide the magnitude; the sign is put back at the end so the
      // quotient truncates toward zero. Each step multiplies the upper part
      // of the magnitude and shifts the next part up behind it.
      if (ctl.load) begin
         neg_in = sum_ff[SUM_W-1];
         mag_in = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
         acc_in = '0;
      end else if (ctl.step) begin
         acc_in = {acc_ff[ACC_W-PART_W-1:0], {PART_W{1'b0}}} + ACC_W'(partial);
         mag_in = {mag_ff[PART_W-1:0], {PART_W{1'b0}}};
      end
      if (ctl.finish) begin
         offset_in = quot - {{(SMP_W-GRAV_W){1'b0}}, adjust};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      offset_ff <= offset_in;
   end

   assign corrected_out = sample_in - offset_ff;

endmodule

[sv/imu_offset_calibrator.sv]
// Top level of the inertial sensor offset calibrator: phase control, lanes, result buffer.
`timescale 1ns / 1ps

// Usage: each input item carries an operation code (identity byte read, wake
// write done, sample frame, bus error), an identity byte and six raw signed
// samples. Every accepted item yields exactly one result item with the phase
// after the item, a sample-valid flag, a calibration-done flag and six
// corrected samples (zero unless the item was a frame in the normal phase).
// An item is accepted when req_valid is high and req_stall is low; a result
// is taken when rsp_valid is high and rsp_stall is low.
// The block takes one item per cycle while req_stall is low; an output
// register plus a one-entry skid register let it keep accepting while a
// result waits, and req_stall rises when the skid register is full. After
// the frame that completes calibration, the six lanes divide their sums by
// SAMPLES by multiplying with a fixed reciprocal, one 16-bit part of the
// sum per cycle, so req_stall stays high through the load, the two multiply
// steps and the finish. The csr port writes the gravity reference at any
// edge with csr_wr_en high. Synchronous reset returns the phase to identity
// check, clears the frame count, empties both result registers and restores
// the gravity reference to 16384.
module imu_offset_calibrator import imuoc_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic [ID_W-1:0]          req_id_byte,
   input  logic signed [SMP_W-1:0]  req_accel_x_in,
   input  logic signed [SMP_W-1:0]  req_accel_y_in,
   input  logic signed [SMP_W-1:0]  req_accel_z_in,
   input  logic signed [SMP_W-1:0]  req_gyro_x_in,
   input  logic signed [SMP_W-1:0]  req_gyro_y_in,
   input  logic signed [SMP_W-1:0]  req_gyro_z_in,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_phase_now,
   output logic                     rsp_sample_valid,
   output logic                     rsp_calibration_done,
   output logic signed [SMP_W-1:0]  rsp_accel_x_out,
   output logic signed [SMP_W-1:0]  rsp_accel_y_out,
   output logic signed [SMP_W-1:0]  rsp_accel_z_out,
   output logic signed [SMP_W-1:0]  rsp_gyro_x_out,
   output logic signed [SMP_W-1:0]  rsp_gyro_y_out,
   output logic signed [SMP_W-1:0]  rsp_gyro_z_out,

   input  logic                     csr_wr_en,
   input  logic [GRAV_W-1:0]        csr_wr_data
);

   // Control state.
   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    frame_count_ff, frame_count_in;
   logic                busy_ff, busy_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [GRAV_W-1:0]   grav_ff, grav_in;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   // Payload registers.
   logic [GRAV_W-1:0]   grav_snap_ff, grav_snap_in;
   result_type          out_ff, out_in;
   result_type          skid_ff, skid_in;

   logic                        req_accept;
   logic                        rsp_take;
   op_type                      op;
   logic [CNT_W:0]              count_next;
   logic                        accumulate;
   logic                        first_frame;
   logic                        final_frame;
   logic                        emit;
   lane_ctl_type                lane_ctl;
   logic [AXES-1:0][SMP_W-1:0]  raw;
   logic [AXES-1:0][SMP_W-1:0]  corrected;
   result_type                  res;

   assign req_stall  = busy_ff | skid_valid_ff;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_take   = out_valid_ff & ~rsp_stall;

   assign raw[0] = req_accel_x_in;
   assign raw[1] = req_accel_y_in;
   assign raw[2] = req_accel_z_in;
   assign raw[3] = req_gyro_x_in;
   assign raw[4] = req_gyro_y_in;
   assign raw[5] = req_gyro_z_in;

   // Phase sequencing and frame counting. A frame is final when the count
   // after it reaches SAMPLES; the averaging then runs in the lanes.
   always_comb begin
      op             = op_type'(req_operation);
      count_next     = {1'b0, frame_count_ff} + (CNT_W + 1)'(1);
      phase_in       = phase_ff;
      frame_count_in = frame_count_ff;
      accumulate     = 1'b0;
      first_frame    = 1'b0;
      final_frame    = 1'b0;
      emit           = 1'b0;

      if (req_accept) begin
         case (op)
            OP_ID_READ: begin
               if (phase_ff == PH_CHECK && req_id_byte == ID_EXPECTED) begin
                  phase_in = PH_WAKE;
               end
            end
            OP_WAKE_DONE: begin
               if (phase_ff == PH_WAKE) begin
                  phase_in = PH_CALIB;
               end
            end
            OP_FRAME: begin
               if (phase_ff == PH_CALIB) begin
                  accumulate  = 1'b1;
                  first_frame = (frame_count_ff == '0);
                  if (count_next >= (CNT_W + 1)'(SAMPLES)) begin
                     final_frame    = 1'b1;
                     frame_count_in = '0;
                     phase_in       = PH_NORMAL;
                  end else begin
                     frame_count_in = count_next[CNT_W-1:0];
                  end
               end else if (phase_ff == PH_NORMAL) begin
                  emit = 1'b1;
               end
            end
            OP_BUS_ERROR: begin
               // A bus error leaves the phase and the frame count unchanged.
            end
            default: begin
            end
         endcase
      end
   end

   // Divider sequencer shared by all six lanes.
   always_comb begin
      busy_in      = busy_ff;
      dcnt_in      = dcnt_ff;
      grav_snap_in = grav_snap_ff;
      grav_in      = csr_wr_en ? csr_wr_data : grav_ff;

      if (final_frame) begin
         busy_in      = 1'b1;
         dcnt_in      = '0;
         grav_snap_in = grav_ff;
      end else if (busy_ff) begin
         if (dcnt_ff == DCNT_W'(DIV_LAST)) begin
            busy_in = 1'b0;
         end else begin
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
      end

      lane_ctl.accumulate = accumulate;
      lane_ctl.first      = first_frame;
      lane_ctl.load       = busy_ff && (dcnt_ff == '0);
      lane_ctl.step       = busy_ff && (dcnt_ff != '0) && (dcnt_ff != DCNT_W'(DIV_LAST));
      lane_ctl.finish     = busy_ff && (dcnt_ff == DCNT_W'(DIV_LAST));
   end

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      imuoc_lane #(
         .SAMPLES (SAMPLES)
      ) u_lane (
         .clock         (clock),
         .ctl           (lane_ctl),
         .sample_in     (raw[a]),
         .adjust        ((a == AXIS_AZ) ? grav_snap_ff : GRAV_W'(0)),
         .corrected_out (corrected[a])
      );
   end

   // Merge the lanes into one result item.
   always_comb begin
      res.phase            = phase_in;
      res.sample_valid     = emit;
      res.calibration_done = (phase_in == PH_NORMAL);
      for (int a = 0; a < AXES; a++) begin
         res.samples[a] = emit ? corrected[a] : '0;
      end
   end

   // Output register with a one-entry skid register behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;

      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CHECK;
         frame_count_ff <= '0;
         busy_ff        <= 1'b0;
         dcnt_ff        <= '0;
         grav_ff        <= GRAVITY_RESET;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         frame_count_ff <= frame_count_in;
         busy_ff        <= busy_in;
         dcnt_ff        <= dcnt_in;
         grav_ff        <= grav_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grav_snap_ff <= grav_snap_in;
      out_ff       <= out_in;
      skid_ff      <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_phase_now        = out_ff.phase;
   assign rsp_sample_valid     = out_ff.sample_valid;
   assign rsp_calibration_done = out_ff.calibration_done;
   assign rsp_accel_x_out      = out_ff.samples[0];
   assign rsp_accel_y_out      = out_ff.samples[1];
   assign rsp_accel_z_out      = out_ff.samples[2];
   assign rsp_gyro_x_out       = out_ff.samples[3];
   assign rsp_gyro_y_out       = out_ff.samples[4];
   assign rsp_gyro_z_out       = out_ff.samples[5];

   // The divider only runs once the phase has moved to normal.
   a_busy_in_normal : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (phase_ff == PH_NORMAL))
      else $error("divider running outside the normal phase");

   // The frame that completes calibration starts the divider at its load step.
   a_final_starts_div : assert property (@(posedge clock) disable iff (reset)
      final_frame |=> (busy_ff && dcnt_ff == '0))
      else $error("divider did not start after the last calibration frame");

   // The divider finishes after its last step.
   a_div_ends : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && dcnt_ff == DCNT_W'(DIV_LAST)) |=> !busy_ff)
      else $error("divider did not finish");

   // The skid register only fills while the output register is occupied.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item ahead of the output register");

   // Corrected samples are only reported once calibration is done.
   a_valid_needs_done : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.sample_valid) |-> out_ff.calibration_done)
      else $error("corrected samples reported before calibration");

endmodule
